FILE: src/sqb_pkg.sv
`default_nettype none
package sqb_pkg;

    localparam int BatchVerticesDefault = 1024;
    localparam int TextureSlotsDefault  = 4;

    localparam logic [1:0] MODE_IMAGE    = 2'd0;
    localparam logic [1:0] MODE_FILL     = 2'd1;
    localparam logic [1:0] MODE_FLUSH    = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_XAXIS_X  = 3'd2;
    localparam logic [2:0] REG_XAXIS_Y  = 3'd3;
    localparam logic [2:0] REG_YAXIS_X  = 3'd4;
    localparam logic [2:0] REG_YAXIS_Y  = 3'd5;
    localparam logic [2:0] REG_LIMIT    = 3'd6;

    localparam logic [2:0]  UNTEXTURED_SLOT = 3'd4;
    localparam logic [17:0] TEX_MAX         = 18'h3FFFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        texture_id;
        logic [31:0]        texture_size;
        logic signed [31:0] dest_left;
        logic signed [31:0] dest_top;
        logic signed [31:0] dest_right;
        logic signed [31:0] dest_bottom;
        logic [15:0]        pix_left;
        logic [15:0]        pix_top;
        logic [15:0]        pix_right;
        logic [15:0]        pix_bottom;
        logic [31:0]        color_rgba;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        vertex_color;
        logic [17:0]        tex_s;
        logic [17:0]        tex_t;
        logic [2:0]         tex_slot;
        logic               slot_loaded;
        logic               batch_start;
        logic               marker_only;
        logic               last;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic               flush;
        logic               textured;
        logic               fresh;
        logic               loaded;
        logic [2:0]         slot;
        logic [31:0]        size;
        logic signed [31:0] dest_left;
        logic signed [31:0] dest_top;
        logic signed [31:0] dest_right;
        logic signed [31:0] dest_bottom;
        logic [15:0]        pix_left;
        logic [15:0]        pix_top;
        logic [15:0]        pix_right;
        logic [15:0]        pix_bottom;
        logic [31:0]        color_rgba;
    } cmd_t;

endpackage
`default_nettype wire

FILE: src/sqb_front.sv
`default_nettype none
module sqb_front
    import sqb_pkg::*;
#(
    parameter int BATCH_VERTICES = BatchVerticesDefault,
    parameter int TEXTURE_SLOTS  = TextureSlotsDefault
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_item,
    input  wire logic [2:0] limit,
    output logic          cmd_valid,
    input  wire logic     cmd_stall,
    output cmd_t          cmd
);
    localparam int VW = $clog2(BATCH_VERTICES + 1);
    localparam int SW = $clog2(TEXTURE_SLOTS + 1);
    localparam int IW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;

    logic [VW-1:0] vcount_reg, vcount_next;
    logic [SW-1:0] scount_reg, scount_next;
    logic [15:0]   tex_mem [TEXTURE_SLOTS];
    logic [31:0]   size_mem [TEXTURE_SLOTS];

    logic          fresh, found, hit, bind_new, accept;
    logic [IW-1:0] hit_idx, slot_idx;
    logic [SW-1:0] lim;
    logic [31:0]   slot_sz;

    assign in_stall = cmd_valid && cmd_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        lim = SW'(limit);
        if (limit == 3'd0)
            lim = SW'(1);
        else if (32'(limit) > TEXTURE_SLOTS)
            lim = SW'(TEXTURE_SLOTS);
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TEXTURE_SLOTS - 1; i >= 0; i--)
        begin
            if (32'(i) < 32'(scount_reg) && tex_mem[i] == in_item.texture_id)
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        fresh = (vcount_reg == '0) ||
                (32'(vcount_reg) + 32'd6 > BATCH_VERTICES);
        bind_new = !hit && (scount_reg < lim);
        found    = hit || bind_new;
        if (in_item.mode == MODE_IMAGE && (fresh || !found))
            fresh = 1'b1;
        slot_idx = hit ? hit_idx : IW'(scount_reg);
        if (fresh)
            slot_idx = '0;
        slot_sz = (hit && !fresh) ? size_mem[hit_idx] : in_item.texture_size;
    end

    always_comb
    begin
        vcount_next = vcount_reg;
        scount_next = scount_reg;
        case (in_item.mode)
            MODE_FLUSH:
            begin
                vcount_next = '0;
                scount_next = (vcount_reg != '0) ? '0 : scount_reg;
            end
            MODE_IMAGE:
            begin
                vcount_next = fresh ? VW'(6) : vcount_reg + VW'(6);
                if (fresh)
                    scount_next = SW'(1);
                else if (bind_new)
                    scount_next = scount_reg + SW'(1);
            end
            MODE_FILL:
            begin
                vcount_next = fresh ? VW'(6) : vcount_reg + VW'(6);
                if (fresh)
                    scount_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            scount_reg <= '0;
            cmd_valid  <= 1'b0;
        end
        else
        begin
            if (accept && in_item.mode != MODE_RESERVED)
            begin
                vcount_reg <= vcount_next;
                scount_reg <= scount_next;
                cmd_valid  <= 1'b1;
            end
            else if (cmd_valid && !cmd_stall)
                cmd_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_item.mode == MODE_IMAGE && (fresh || bind_new))
        begin
            tex_mem[slot_idx]  <= in_item.texture_id;
            size_mem[slot_idx] <= in_item.texture_size;
        end
        if (accept && in_item.mode != MODE_RESERVED)
        begin
            cmd.flush       <= (in_item.mode == MODE_FLUSH);
            cmd.textured    <= (in_item.mode == MODE_IMAGE);
            cmd.fresh       <= fresh;
            cmd.loaded      <= (in_item.mode == MODE_IMAGE) && (fresh || bind_new);
            cmd.slot        <= (in_item.mode == MODE_IMAGE) ? 3'(slot_idx) : UNTEXTURED_SLOT;
            cmd.size        <= slot_sz;
            cmd.dest_left   <= in_item.dest_left;
            cmd.dest_top    <= in_item.dest_top;
            cmd.dest_right  <= in_item.dest_right;
            cmd.dest_bottom <= in_item.dest_bottom;
            cmd.pix_left    <= in_item.pix_left;
            cmd.pix_top     <= in_item.pix_top;
            cmd.pix_right   <= in_item.pix_right;
            cmd.pix_bottom  <= in_item.pix_bottom;
            cmd.color_rgba  <= in_item.color_rgba;
        end
    end
endmodule
`default_nettype wire

FILE: src/sqb_div.sv
`default_nettype none
module sqb_div
    import sqb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] num,
    input  wire logic [15:0] den,
    output logic             busy,
    output logic [17:0]      quo
);
    // restoring division of num<<16 by den, one quotient bit per cycle
    logic [5:0]  cnt_reg;
    logic [31:0] dvd_reg;
    logic [16:0] rem_reg;
    logic [31:0] q_reg;
    logic [15:0] den_reg;
    logic [16:0] trial;

    assign busy  = (cnt_reg != 6'd0);
    assign trial = {rem_reg[15:0], dvd_reg[31]};

    always_comb
    begin
        if (den_reg == 16'd0 || q_reg[31:18] != 14'd0)
            quo = TEX_MAX;
        else
            quo = q_reg[17:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 6'd0;
        else if (start)
            cnt_reg <= 6'd32;
        else if (busy)
            cnt_reg <= cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, 16'd0};
            rem_reg <= '0;
            q_reg   <= '0;
            den_reg <= den;
        end
        else if (busy)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[30:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/sqb_back.sv
`default_nettype none
module sqb_back
    import sqb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire cmd_t        cmd,
    input  wire logic [31:0] origin_x,
    input  wire logic [31:0] origin_y,
    input  wire logic [31:0] xaxis_x,
    input  wire logic [31:0] xaxis_y,
    input  wire logic [31:0] yaxis_x,
    input  wire logic [31:0] yaxis_y,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_item
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg;
    cmd_t        c_reg;
    logic [1:0]  div_idx_reg;
    logic        div_go_reg, div_go_next;
    logic [17:0] s0_reg, s1_reg, t0_reg, t1_reg;
    logic [2:0]  k_reg;
    logic [1:0]  m_reg;
    logic signed [63:0] p_reg [4];
    logic signed [65:0] acc_x_reg, acc_y_reg;

    logic [15:0] dnum, dden;
    logic        dbusy;
    logic [17:0] dquo;
    logic signed [31:0] cx, cy, ma, mb;
    logic signed [63:0] prod;
    logic signed [65:0] sx, sy;
    logic signed [31:0] px, py;
    logic        left, top;
    logic        emit;

    sqb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (dnum),
        .den   (dden),
        .busy  (dbusy),
        .quo   (dquo)
    );

    always_comb
    begin
        case (div_idx_reg)
            2'd0:    begin dnum = c_reg.pix_left;   dden = c_reg.size[15:0];  end
            2'd1:    begin dnum = c_reg.pix_right;  dden = c_reg.size[15:0];  end
            2'd2:    begin dnum = c_reg.pix_top;    dden = c_reg.size[31:16]; end
            default: begin dnum = c_reg.pix_bottom; dden = c_reg.size[31:16]; end
        endcase
    end

    always_comb
    begin
        case (k_reg)
            3'd0:    begin left = 1'b1; top = 1'b1; end
            3'd1:    begin left = 1'b0; top = 1'b1; end
            3'd2:    begin left = 1'b1; top = 1'b0; end
            3'd3:    begin left = 1'b0; top = 1'b1; end
            3'd4:    begin left = 1'b0; top = 1'b0; end
            default: begin left = 1'b1; top = 1'b0; end
        endcase
        cx = left ? c_reg.dest_left : c_reg.dest_right;
        cy = top ? c_reg.dest_top : c_reg.dest_bottom;
        case (m_reg)
            2'd0:    begin ma = xaxis_x; mb = cx; end
            2'd1:    begin ma = yaxis_x; mb = cy; end
            2'd2:    begin ma = xaxis_y; mb = cx; end
            default: begin ma = yaxis_y; mb = cy; end
        endcase
        prod = ma * mb;
        // floor of the exact sum equals floor of the full-precision total
        sx = {{18{origin_x[31]}}, origin_x, 16'd0}
           + {{2{p_reg[0][63]}}, p_reg[0]} + {{2{p_reg[1][63]}}, p_reg[1]};
        sy = {{18{origin_y[31]}}, origin_y, 16'd0}
           + {{2{p_reg[2][63]}}, p_reg[2]} + {{2{p_reg[3][63]}}, p_reg[3]};
    end

    function automatic logic [31:0] sat(input logic signed [65:0] v);
        if (v[65] && !(&v[65:47]))
            sat = 32'h8000_0000;
        else if (!v[65] && (|v[64:47]))
            sat = 32'h7FFF_FFFF;
        else
            sat = v[47:16];
    endfunction

    assign px = sat(acc_x_reg);
    assign py = sat(acc_y_reg);
    assign cmd_stall = (state_reg != ST_IDLE);
    assign emit = (state_reg == ST_OUT) && (!out_valid || !out_stall);
    assign div_go_next =
        (state_reg == ST_IDLE && cmd_valid && !cmd.flush && cmd.textured) ||
        (state_reg == ST_DIV && !dbusy && !div_go_reg && div_idx_reg != 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_valid   <= 1'b0;
            div_go_reg  <= 1'b0;
            div_idx_reg <= '0;
            k_reg       <= '0;
            m_reg       <= '0;
        end
        else
        begin
            div_go_reg <= div_go_next;
            if (emit)
                out_valid <= 1'b1;
            else if (out_valid && !out_stall)
                out_valid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        k_reg <= '0;
                        m_reg <= '0;
                        if (cmd.flush)
                            state_reg <= ST_OUT;
                        else if (cmd.textured)
                        begin
                            div_idx_reg <= '0;
                            state_reg   <= ST_DIV;
                        end
                        else
                            state_reg <= ST_MUL;
                    end
                end
                ST_DIV:
                begin
                    if (!dbusy && !div_go_reg)
                    begin
                        div_idx_reg <= div_idx_reg + 2'd1;
                        if (div_idx_reg == 2'd3)
                            state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    m_reg <= m_reg + 2'd1;
                    if (m_reg == 2'd3)
                        state_reg <= ST_SUM;
                end
                ST_SUM:
                    state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (emit)
                    begin
                        if (c_reg.flush || k_reg == 3'd5)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            c_reg  <= cmd;
            s0_reg <= '0;
            s1_reg <= '0;
            t0_reg <= '0;
            t1_reg <= '0;
        end
        if (state_reg == ST_DIV && !dbusy && !div_go_reg)
        begin
            case (div_idx_reg)
                2'd0:    s0_reg <= dquo;
                2'd1:    s1_reg <= dquo;
                2'd2:    t0_reg <= dquo;
                default: t1_reg <= dquo;
            endcase
        end
        if (state_reg == ST_MUL)
            p_reg[m_reg] <= prod;
        if (state_reg == ST_SUM)
        begin
            acc_x_reg <= sx;
            acc_y_reg <= sy;
        end
        if (emit)
        begin
            if (c_reg.flush)
            begin
                out_item.pos_x        <= '0;
                out_item.pos_y        <= '0;
                out_item.vertex_color <= '0;
                out_item.tex_s        <= '0;
                out_item.tex_t        <= '0;
                out_item.tex_slot     <= UNTEXTURED_SLOT;
                out_item.slot_loaded  <= 1'b0;
                out_item.batch_start  <= 1'b0;
                out_item.marker_only  <= 1'b1;
                out_item.last         <= 1'b1;
            end
            else
            begin
                out_item.pos_x        <= px;
                out_item.pos_y        <= py;
                out_item.vertex_color <= c_reg.color_rgba;
                out_item.tex_s        <= left ? s0_reg : s1_reg;
                out_item.tex_t        <= top ? t0_reg : t1_reg;
                out_item.tex_slot     <= c_reg.slot;
                out_item.slot_loaded  <= c_reg.loaded;
                out_item.batch_start  <= c_reg.fresh && (k_reg == 3'd0);
                out_item.marker_only  <= 1'b0;
                out_item.last         <= (k_reg == 3'd5);
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/sprite_quad_batch_setup_core.sv
`default_nettype none
// Turns image, fill and flush commands into vertex beats: six per rectangle,
// one marker beat per flush. A textured rectangle first runs four 32-step
// serial divisions for the texture coordinates; each vertex then takes four
// products on the shared multiplier, one sum and one output step. A fill
// skips the divisions, and a flush goes straight to its output; output stalls
// hold the back. The front keeps the slot table and batch count and takes
// the next command while the back works.
module sprite_quad_batch_setup_core
    import sqb_pkg::*;
#(
    parameter int BATCH_VERTICES = BatchVerticesDefault,
    parameter int TEXTURE_SLOTS  = TextureSlotsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_item,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic [31:0] origin_x_reg, origin_y_reg, xaxis_x_reg, xaxis_y_reg;
    logic [31:0] yaxis_x_reg, yaxis_y_reg;
    logic [2:0]  limit_reg;
    logic        cmd_valid, cmd_stall;
    cmd_t        cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            xaxis_x_reg  <= 32'h0001_0000;
            xaxis_y_reg  <= '0;
            yaxis_x_reg  <= '0;
            yaxis_y_reg  <= 32'h0001_0000;
            limit_reg    <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_data;
                REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                REG_XAXIS_X:  xaxis_x_reg  <= cfg_data;
                REG_XAXIS_Y:  xaxis_y_reg  <= cfg_data;
                REG_YAXIS_X:  yaxis_x_reg  <= cfg_data;
                REG_YAXIS_Y:  yaxis_y_reg  <= cfg_data;
                REG_LIMIT:    limit_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    sqb_front #(
        .BATCH_VERTICES (BATCH_VERTICES),
        .TEXTURE_SLOTS  (TEXTURE_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .limit     (limit_reg),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd)
    );

    sqb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .xaxis_x   (xaxis_x_reg),
        .xaxis_y   (xaxis_y_reg),
        .yaxis_x   (yaxis_x_reg),
        .yaxis_y   (yaxis_y_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );
endmodule
`default_nettype wire

FILE: verif/tb_sprite_quad_batch_setup_core.sv
`default_nettype none
module tb_sprite_quad_batch_setup_core;
    import sqb_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    sprite_quad_batch_setup_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    localparam int BatchVertices = BatchVerticesDefault;
    localparam int TextureSlots  = TextureSlotsDefault;

    in_item_t  cmd_queue[$];
    out_item_t vertex_queue[$];
    int errors;
    int calm_left;
    int hold_left;
    bit hold_armed;
    int sent_count;

    logic signed [31:0] xf_reg[6];
    logic [2:0] limit_reg;
    int unsigned batch_verts;
    int unsigned bound_count;
    logic [15:0] bound_id[TextureSlots];
    logic [31:0] bound_size[TextureSlots];

    function automatic logic signed [31:0] affine(logic signed [31:0] c0,
        logic signed [31:0] a, logic signed [31:0] b,
        logic signed [31:0] x, logic signed [31:0] y);
        logic signed [95:0] sum;
        logic signed [95:0] q;
        sum = (96'(signed'(64'(a))) * 96'(signed'(64'(x))))
            + (96'(signed'(64'(b))) * 96'(signed'(64'(y))))
            + (96'(signed'(64'(c0))) <<< 16);
        q = sum >>> 16;
        if (q > 96'sd2147483647)
            return 32'h7FFFFFFF;
        if (q < -96'sd2147483648)
            return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic logic [17:0] tex_ratio(logic [15:0] src, logic [15:0] dim);
        logic [47:0] q;
        if (dim == 0)
            return TEX_MAX;
        q = {16'd0, src, 16'd0} / dim;
        return (q > 48'(TEX_MAX)) ? TEX_MAX : q[17:0];
    endfunction

    task automatic predict_vertices(input in_item_t c);
        out_item_t v;
        logic signed [31:0] cx[6];
        logic signed [31:0] cy[6];
        logic [17:0] cs[6];
        logic [17:0] ct[6];
        logic [2:0] slot;
        logic [17:0] s0, s1, t0, t1;
        logic [31:0] sz;
        bit fresh, found, loaded;
        int unsigned lim;
        if (c.mode == MODE_RESERVED)
            return;
        if (c.mode == MODE_FLUSH) begin
            v = '0;
            v.tex_slot = UNTEXTURED_SLOT;
            v.marker_only = 1'b1;
            v.last = 1'b1;
            vertex_queue.push_back(v);
            if (batch_verts > 0) begin
                batch_verts = 0;
                bound_count = 0;
            end
            return;
        end
        fresh = (batch_verts == 0) || (batch_verts + 6 > BatchVertices);
        slot = UNTEXTURED_SLOT;
        loaded = 0;
        found = 0;
        for (int k = 0; k < 6; k++) begin
            cs[k] = '0;
            ct[k] = '0;
        end
        if (c.mode == MODE_IMAGE) begin
            lim = limit_reg;
            if (lim < 1)
                lim = 1;
            if (lim > TextureSlots)
                lim = TextureSlots;
            for (int i = 0; i < bound_count && !found; i++)
                if (bound_id[i] == c.texture_id) begin
                    slot = 3'(i);
                    found = 1;
                end
            if (!found && bound_count < lim) begin
                slot = 3'(bound_count);
                bound_id[bound_count] = c.texture_id;
                bound_size[bound_count] = c.texture_size;
                bound_count++;
                found = 1;
                loaded = 1;
            end
            if (fresh || !found) begin
                fresh = 1;
                slot = 3'd0;
                bound_id[0] = c.texture_id;
                bound_size[0] = c.texture_size;
                bound_count = 1;
                loaded = 1;
            end
            sz = bound_size[slot];
            s0 = tex_ratio(c.pix_left, sz[15:0]);
            s1 = tex_ratio(c.pix_right, sz[15:0]);
            t0 = tex_ratio(c.pix_top, sz[31:16]);
            t1 = tex_ratio(c.pix_bottom, sz[31:16]);
            cs = '{s0, s1, s0, s1, s1, s0};
            ct = '{t0, t0, t1, t0, t1, t1};
        end else if (fresh) begin
            bound_count = 0;
        end
        cx = '{c.dest_left, c.dest_right, c.dest_left, c.dest_right, c.dest_right,
               c.dest_left};
        cy = '{c.dest_top, c.dest_top, c.dest_bottom, c.dest_top, c.dest_bottom,
               c.dest_bottom};
        for (int k = 0; k < 6; k++) begin
            v = '0;
            v.pos_x = affine(xf_reg[0], xf_reg[2], xf_reg[4], cx[k], cy[k]);
            v.pos_y = affine(xf_reg[1], xf_reg[3], xf_reg[5], cx[k], cy[k]);
            v.vertex_color = c.color_rgba;
            v.tex_s = cs[k];
            v.tex_t = ct[k];
            v.tex_slot = slot;
            v.slot_loaded = loaded;
            v.batch_start = (k == 0) && fresh;
            v.last = (k == 5);
            vertex_queue.push_back(v);
        end
        batch_verts = fresh ? 6 : batch_verts + 6;
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< 16;
            3: return 32'(signed'($urandom_range(0, 200)) - 100) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t rand_cmd(int id_span);
        in_item_t c;
        int r;
        c.texture_id = 16'($urandom_range(0, id_span));
        c.texture_size = ($urandom_range(0, 15) == 0) ? $urandom
                       : {16'($urandom_range(1, 512)), 16'($urandom_range(1, 512))};
        if ($urandom_range(0, 20) == 0)
            c.texture_size[$urandom_range(0, 1) * 16 +: 16] = 16'd0;
        c.texture_id = (c.texture_id == 0 && $urandom_range(0, 9) == 0) ? 16'hFFFF
                                                                         : c.texture_id;
        c.texture_size = c.texture_size;
        c.dest_left = pick32();
        c.dest_top = pick32();
        c.dest_right = pick32();
        c.dest_bottom = pick32();
        c.pix_left = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
        c.pix_top = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
        c.pix_right = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
        c.pix_bottom = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
        c.color_rgba = $urandom;
        r = $urandom_range(0, 99);
        if (r < 65)
            c.mode = MODE_IMAGE;
        else if (r < 85)
            c.mode = MODE_FILL;
        else if (r < 97)
            c.mode = MODE_FLUSH;
        else
            c.mode = MODE_RESERVED;
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LIMIT)
            limit_reg = val[2:0];
        else
            xf_reg[idx] = val;
    endtask

    task automatic wait_drained();
        wait (cmd_queue.size() == 0 && !in_valid && vertex_queue.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic send(input in_item_t c);
        cmd_queue.push_back(c);
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #200000000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (cmd_queue.size() > 0 && (calm_left > 0 || $urandom_range(0, 99) >= 20)) begin
                in_item <= cmd_queue[0];
                predict_vertices(cmd_queue.pop_front());
                in_valid <= 1'b1;
                sent_count++;
            end else begin
                in_valid <= 1'b0;
            end
        end
        if (calm_left > 0)
            calm_left--;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (vertex_queue.size() == 0) begin
                    $display("%0t unexpected beat %h", $time, out_item);
                    errors++;
                end else if (out_item !== vertex_queue[0]) begin
                    $display("%0t mismatch expected %h actual %h", $time, vertex_queue[0],
                             out_item);
                    errors++;
                    void'(vertex_queue.pop_front());
                end else begin
                    void'(vertex_queue.pop_front());
                end
            end
            if (hold_armed && sent_count > 150) begin
                hold_armed = 0;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= (calm_left > 0) ? 1'b0 : ($urandom_range(0, 99) < 20);
            end
        end
    end

    initial begin
        in_item_t c;
        errors = 0;
        sent_count = 0;
        calm_left = 0;
        hold_left = 0;
        hold_armed = 1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data = '0;
        xf_reg = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd65536};
        limit_reg = 3'd4;
        batch_verts = 0;
        bound_count = 0;
        for (int i = 0; i < TextureSlots; i++) begin
            bound_id[i] = '0;
            bound_size[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        c = '0;
        c.mode = MODE_FLUSH;
        send(c);
        c.mode = MODE_IMAGE;
        c.texture_id = 16'd1;
        c.texture_size = {16'd64, 16'd32};
        c.dest_left = 32'sd0;
        c.dest_top = 32'sd0;
        c.dest_right = 32'sh00200000;
        c.dest_bottom = 32'sh00400000;
        c.pix_right = 16'd32;
        c.pix_bottom = 16'd64;
        c.color_rgba = 32'hFFFFFFFF;
        send(c);
        for (int i = 2; i <= 6; i++) begin
            c.texture_id = 16'(i);
            send(c);
        end
        c.texture_id = 16'd3;
        send(c);
        c.texture_id = 16'hFFFF;
        c.texture_size = 32'd0;
        c.pix_left = 16'hFFFF;
        c.pix_top = 16'hFFFF;
        c.pix_right = 16'hFFFF;
        c.pix_bottom = 16'hFFFF;
        send(c);
        c.texture_size = 32'hFFFFFFFF;
        c.dest_left = 32'sh7FFFFFFF;
        c.dest_top = 32'sh80000000;
        c.dest_right = 32'sh80000000;
        c.dest_bottom = 32'sh7FFFFFFF;
        send(c);
        c.mode = MODE_FILL;
        c.color_rgba = 32'h0;
        send(c);
        c.mode = MODE_RESERVED;
        send(c);
        c.mode = MODE_FLUSH;
        send(c);
        send(c);
        c.mode = MODE_FILL;
        send(c);
        wait_drained();

        write_reg(REG_ORIGIN_X, 32'h7FFFFFFF);
        write_reg(REG_ORIGIN_Y, 32'h80000000);
        write_reg(REG_XAXIS_X, 32'h80000000);
        write_reg(REG_XAXIS_Y, 32'h7FFFFFFF);
        write_reg(REG_YAXIS_X, 32'h7FFFFFFF);
        write_reg(REG_YAXIS_Y, 32'h80000000);
        write_reg(REG_LIMIT, 32'd0);
        for (int n = 0; n < 12; n++)
            send(rand_cmd(3));
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            for (int r = 0; r < 6; r++)
                write_reg(3'(r), (ph == 0) ? ((r == 2 || r == 5) ? 32'h00010000 : 32'h0)
                                          : pick32());
            write_reg(REG_LIMIT, (ph == 1) ? 32'd7 : 32'($urandom_range(1, 4)));
            if (ph == 2)
                calm_left = 3000;
            for (int n = 0; n < 84; n++)
                send(rand_cmd((ph == 3) ? 40 : 6));
            wait_drained();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sprite_quad_batch_setup_core.f
src/sqb_pkg.sv
src/sqb_front.sv
src/sqb_div.sv
src/sqb_back.sv
src/sprite_quad_batch_setup_core.sv
verif/tb_sprite_quad_batch_setup_core.sv
